// ----- src/scfm_pkg.sv -----
// Shared types, constants and sine lookup for the selcall tone sequence FM modulator.
package scfm_pkg;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_LOAD_DIGIT = 2'd1,
    MODE_LOAD_TONE  = 2'd2,
    MODE_START      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_TONE_STEPS    = 2'd0,
    REG_SILENCE_STEPS = 2'd1,
    REG_FM_GAIN       = 2'd2
  } reg_idx_t;

  localparam logic [15:0] SPT_RESET       = 16'd30720;
  localparam logic [15:0] SILENCE_RESET   = 16'd3072;
  localparam logic [11:0] GAIN_RESET      = 12'd853;
  localparam logic [7:0]  END_DIGIT       = 8'hFF;
  localparam logic [7:0]  CARRIER_QUARTER = 8'd64;

  localparam int PHASE_W  = 26;
  localparam int SINE_LSB = 18;
  localparam int DELTA_W  = 20;

  // Command from the input channel to the sequencer, valid only on acceptance.
  typedef struct packed {
    logic       tick;
    logic       start;
    logic       dig_wr;
    logic [4:0] slot;
    logic [7:0] digit;
  } seq_cmd_t;

  // Per-tick control result produced by the sequencer.
  typedef struct packed {
    logic       tone_adv;
    logic       carrier_en;
    logic       running;
    logic       advanced;
    logic [4:0] digits_done;
    logic       finished;
    logic [3:0] tone_idx;
  } tick_info_t;

  localparam logic [7:0] QUARTER_SINE [65] = '{
    8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd16,  8'd19,  8'd22,
    8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
    8'd49,  8'd51,  8'd54,  8'd57,  8'd60,  8'd63,  8'd65,  8'd68,
    8'd71,  8'd73,  8'd76,  8'd78,  8'd81,  8'd83,  8'd85,  8'd88,
    8'd90,  8'd92,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd104,
    8'd106, 8'd107, 8'd109, 8'd111, 8'd112, 8'd113, 8'd115, 8'd116,
    8'd117, 8'd118, 8'd120, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124,
    8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127,
    8'd127
  };

  // Full-cycle signed sine from a quarter-wave table.
  function automatic logic signed [7:0] sine_lut(input logic [7:0] k);
    logic [6:0] addr;
    logic [7:0] mag;
    addr = k[6] ? (7'd64 - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
    mag  = QUARTER_SINE[addr];
    return k[7] ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

// ----- src/scfm_seq.sv -----
// Tone sequencer: control state, digit store with prefetch of the next digit.
module scfm_seq
  import scfm_pkg::*;
#(
  parameter int MESSAGE_SLOTS = 21,
  parameter int TONE_DIVIDE   = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  seq_cmd_t   cmd,
  input  logic [15:0] tone_steps,
  input  logic [15:0] silence_steps,
  output tick_info_t info
);

  localparam int         DAW      = $clog2(MESSAGE_SLOTS);
  localparam logic [4:0] SLOTS5   = 5'(MESSAGE_SLOTS);
  localparam logic [2:0] DIV_LAST = 3'(TONE_DIVIDE - 1);

  logic [7:0]  dig_mem [MESSAGE_SLOTS];

  logic [2:0]  div_r, div_nxt;
  logic        silent_r, silent_nxt;
  logic        active_r, active_nxt;
  logic [15:0] step_r, step_nxt;
  logic [4:0]  ptr_r, ptr_nxt;
  logic [3:0]  cur_r, cur_nxt;
  logic [7:0]  pf_r;

  logic [4:0]     ptr_inc;
  logic           wr_en;
  logic [DAW-1:0] rd_idx;
  logic           fwd;

  assign ptr_inc = ptr_r + 5'd1;
  assign wr_en   = cmd.dig_wr && (cmd.slot < SLOTS5);
  assign rd_idx  = (ptr_nxt < SLOTS5) ? ptr_nxt[DAW-1:0] : '0;
  assign fwd     = wr_en && (cmd.slot == ptr_nxt);

  always_comb begin
    div_nxt    = div_r;
    silent_nxt = silent_r;
    active_nxt = active_r;
    step_nxt   = step_r;
    ptr_nxt    = ptr_r;
    cur_nxt    = cur_r;
    info       = '0;
    if (cmd.start) begin
      ptr_nxt    = '0;
      cur_nxt    = '0;
      step_nxt   = tone_steps;
      silent_nxt = 1'b1;
      active_nxt = 1'b1;
    end else if (cmd.tick && active_r) begin
      if (div_r >= DIV_LAST) begin
        div_nxt = '0;
        if (silent_r) begin
          if (step_r >= silence_steps) begin
            silent_nxt = 1'b0;
            step_nxt   = tone_steps;
          end else begin
            step_nxt = step_r + 16'd1;
          end
        end else begin
          info.tone_adv = 1'b1;
          if (step_r >= tone_steps) begin
            // fetch the prefetched digit; end on the stop digit or past the last slot
            cur_nxt  = pf_r[3:0];
            ptr_nxt  = ptr_inc;
            step_nxt = '0;
            if (pf_r == END_DIGIT || ptr_inc >= SLOTS5) begin
              active_nxt    = 1'b0;
              info.finished = 1'b1;
              info.tone_adv = 1'b0;
            end else begin
              info.advanced = 1'b1;
            end
          end else begin
            step_nxt = step_r + 16'd1;
          end
        end
      end else begin
        div_nxt = div_r + 3'd1;
      end
    end
    info.carrier_en  = active_nxt && !silent_nxt;
    info.running     = active_nxt;
    info.digits_done = ptr_nxt;
    info.tone_idx    = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r    <= '0;
      silent_r <= 1'b1;
      active_r <= 1'b0;
      step_r   <= '0;
      ptr_r    <= '0;
      cur_r    <= '0;
    end else begin
      div_r    <= div_nxt;
      silent_r <= silent_nxt;
      active_r <= active_nxt;
      step_r   <= step_nxt;
      ptr_r    <= ptr_nxt;
      cur_r    <= cur_nxt;
    end
  end

  // Digit store: one write port, one read port tracking the next pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dig_mem[cmd.slot[DAW-1:0]] <= cmd.digit;
    end
  end

  // Forward a same-cycle write so the prefetch always matches the store.
  always_ff @(posedge clk) begin
    pf_r <= fwd ? cmd.digit : dig_mem[rd_idx];
  end

endmodule

// ----- src/selcall_tone_sequence_fm_modulator_unit.sv -----
// Top level of the selcall tone sequence FM modulator: ports, config, FM datapath pipeline.
// A tick transaction passes stages 1 to 4 and then the output register before its result shows on out_*.
// Throughput: one transaction per cycle while in_ready is high; load and start transactions give no result.
// The output register and per-stage valid bits let input accept while a result waits.
// Reset (synchronous, rst_n low): sequencer idle, accumulators and counters zero,
// config at defaults; digit and tone stores hold undefined data until loaded.
module selcall_tone_sequence_fm_modulator_unit
  import scfm_pkg::*;
#(
  parameter int MESSAGE_SLOTS = 21,
  parameter int TONE_DIVIDE   = 5,
  parameter int TONE_COUNT    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [4:0]         in_slot,
  input  logic [25:0]        in_load_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  out_i_sample,
  output logic signed [7:0]  out_q_sample,
  output logic               out_running,
  output logic               out_digit_advanced,
  output logic [4:0]         out_digits_done,
  output logic               out_finished,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int         TAW  = $clog2(TONE_COUNT);
  localparam logic [4:0] TC5  = 5'(TONE_COUNT);

  // ---------------------------------------------------------------------------
  // Configuration registers (the user writes them only while idle; the block itself does not enforce this)
  // ---------------------------------------------------------------------------
  logic [15:0] spt_r;
  logic [15:0] silence_r;
  logic [11:0] gain_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r     <= SPT_RESET;
      silence_r <= SILENCE_RESET;
      gain_r    <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TONE_STEPS:    spt_r     <= cfg_pwdata[15:0];
        REG_SILENCE_STEPS: silence_r <= cfg_pwdata[15:0];
        REG_FM_GAIN:       gain_r    <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TONE_STEPS:    cfg_prdata = {16'd0, spt_r};
      REG_SILENCE_STEPS: cfg_prdata = {16'd0, silence_r};
      REG_FM_GAIN:       cfg_prdata = {20'd0, gain_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage advances when it is empty or the stage
  // after it advances, so bubbles collapse and input keeps flowing behind a
  // stalled output register.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic en1, en2, en3, en4, en_out;

  assign en_out   = !out_v_r || out_ready;
  assign en4      = !s4_v_r || en_out;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;
  assign out_valid = out_v_r;

  logic accept;
  logic tick_acc;

  assign accept   = in_valid && in_ready;
  assign tick_acc = accept && (in_mode == MODE_TICK);

  // ---------------------------------------------------------------------------
  // Stage 0: sequencer updates its control state on acceptance
  // ---------------------------------------------------------------------------
  seq_cmd_t   cmd;
  tick_info_t info;

  always_comb begin
    cmd        = '0;
    cmd.tick   = tick_acc;
    cmd.start  = accept && (in_mode == MODE_START);
    cmd.dig_wr = accept && (in_mode == MODE_LOAD_DIGIT);
    cmd.slot   = in_slot;
    cmd.digit  = in_load_value[7:0];
  end

  scfm_seq #(
    .MESSAGE_SLOTS (MESSAGE_SLOTS),
    .TONE_DIVIDE   (TONE_DIVIDE)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .tone_steps    (spt_r),
    .silence_steps (silence_r),
    .info          (info)
  );

  // ---------------------------------------------------------------------------
  // Tone increment table: written by load transactions, read once per tick
  // at acceptance with the digit index the tick leaves behind.
  // ---------------------------------------------------------------------------
  logic [25:0]    tone_mem [TONE_COUNT];
  logic [25:0]    tone_rd_r;
  logic           tone_wr;
  logic           idx_oob;
  logic [TAW-1:0] tone_rd_idx;

  assign tone_wr     = accept && (in_mode == MODE_LOAD_TONE) && (in_slot < TC5);
  assign idx_oob     = {1'b0, info.tone_idx} >= TC5;
  assign tone_rd_idx = idx_oob ? '0 : info.tone_idx[TAW-1:0];

  always_ff @(posedge clk) begin
    if (tone_wr) begin
      tone_mem[in_slot[TAW-1:0]] <= in_load_value;
    end
  end

  // Read register holds while stage 1 is stalled: it loads only on a tick.
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      tone_rd_r <= tone_mem[tone_rd_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------------
  tick_info_t s1_info_r, s2_info_r, s3_info_r, s4_info_r;
  logic       s1_oob_r;

  logic [PHASE_W-1:0] tone_acc_r, tone_acc_nxt;
  logic [PHASE_W-1:0] carrier_acc_r, carrier_acc_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [7:0]  tone_sine;
  logic signed [DELTA_W-1:0] gain_s;
  logic [25:0]        tone_inc;
  logic signed [7:0]  i_nxt, q_nxt;

  // Stage 1 -> 2: advance the tone phase by the table increment.
  assign tone_inc     = s1_oob_r ? '0 : tone_rd_r;
  assign tone_acc_nxt = s1_info_r.tone_adv ? (tone_acc_r + tone_inc) : tone_acc_r;

  // Stage 2 -> 3: tone sine times gain gives the carrier phase step.
  assign tone_sine = sine_lut(tone_acc_r[PHASE_W-1:SINE_LSB]);
  assign gain_s    = $signed({8'd0, gain_r});
  assign delta_nxt = $signed(DELTA_W'(tone_sine)) * gain_s;

  // Stage 3 -> 4: accumulate the carrier phase while a tone is on air.
  assign carrier_acc_nxt = s3_info_r.carrier_en
                         ? (carrier_acc_r + unsigned'(PHASE_W'(delta_r)))
                         : carrier_acc_r;

  // Stage 4 -> out: cosine and sine of the carrier phase, zero when silent.
  always_comb begin
    if (s4_info_r.carrier_en) begin
      i_nxt = sine_lut(carrier_acc_r[PHASE_W-1:SINE_LSB] + CARRIER_QUARTER);
      q_nxt = sine_lut(carrier_acc_r[PHASE_W-1:SINE_LSB]);
    end else begin
      i_nxt = '0;
      q_nxt = '0;
    end
  end

  // Valid bits and phase accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      s4_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      tone_acc_r    <= '0;
      carrier_acc_r <= '0;
    end else begin
      if (en1)    s1_v_r  <= tick_acc;
      if (en2)    s2_v_r  <= s1_v_r;
      if (en3)    s3_v_r  <= s2_v_r;
      if (en4)    s4_v_r  <= s3_v_r;
      if (en_out) out_v_r <= s4_v_r;
      if (en2 && s1_v_r) tone_acc_r    <= tone_acc_nxt;
      if (en4 && s3_v_r) carrier_acc_r <= carrier_acc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_info_r <= info;
      s1_oob_r  <= idx_oob;
    end
    if (en2 && s1_v_r) s2_info_r <= s1_info_r;
    if (en3 && s2_v_r) begin
      s3_info_r <= s2_info_r;
      delta_r   <= delta_nxt;
    end
    if (en4 && s3_v_r) s4_info_r <= s3_info_r;
    if (en_out && s4_v_r) begin
      out_i_sample       <= i_nxt;
      out_q_sample       <= q_nxt;
      out_running        <= s4_info_r.running;
      out_digit_advanced <= s4_info_r.advanced;
      out_digits_done    <= s4_info_r.digits_done;
      out_finished       <= s4_info_r.finished;
    end
  end

endmodule

// ----- src/scfm_chk.sv -----
// Port-level checker for the selcall tone sequence FM modulator, with its bind.
module scfm_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_i_sample,
  input logic signed [7:0] out_q_sample,
  input logic              out_running,
  input logic              out_digit_advanced,
  input logic [4:0]        out_digits_done,
  input logic              out_finished
);

  // The ending step drops the block to idle in the same transaction.
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_running)
    else $error("finished transaction still reports running");

  // A digit fetch that did not end the sequence keeps it running.
  a_adv_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_advanced |-> out_running && !out_finished)
    else $error("digit advance outside a running sequence");

  // Idle output is silent carrier.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |-> out_i_sample == 8'sd0 && out_q_sample == 8'sd0)
    else $error("nonzero sample while idle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_i_sample)
      && $stable(out_q_sample) && $stable(out_digits_done))
    else $error("result changed while stalled");

endmodule

bind selcall_tone_sequence_fm_modulator_unit scfm_chk u_scfm_chk (.*);

// ----- bench/scfm_checker.sv -----
// Scoreboard for the selcall FM modulator: tracks config, predicts each tick result, compares.
`timescale 1ns / 1ps
module scfm_checker
  import scfm_pkg::*;
#(
  parameter int MESSAGE_SLOTS = 21,
  parameter int TONE_DIVIDE   = 5,
  parameter int TONE_COUNT    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [4:0]        in_slot,
  input  logic [25:0]       in_load_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [7:0] out_i_sample,
  input  logic signed [7:0] out_q_sample,
  input  logic              out_running,
  input  logic              out_digit_advanced,
  input  logic [4:0]        out_digits_done,
  input  logic              out_finished,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                pending_samples
);

  typedef struct {
    logic signed [7:0] i_sample;
    logic signed [7:0] q_sample;
    logic              running;
    logic              digit_advanced;
    logic [4:0]        digits_done;
    logic              finished;
  } iq_result_t;

  iq_result_t  expected_samples[$];

  logic [15:0] spt_reg;
  logic [15:0] silence_reg;
  logic [11:0] gain_reg;

  logic [7:0]  digit_mem [32];
  logic [25:0] tone_mem  [16];
  logic [2:0]  div_cnt;
  logic        lead_in;
  logic        seq_active;
  logic [15:0] step_cnt;
  logic [4:0]  dig_ptr;
  logic [7:0]  cur_digit;
  logic [25:0] tone_acc;
  logic [25:0] carrier_acc;

  iq_result_t  got_exp;

  initial mismatch_count = 0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 100) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Signed sine of the top 8 phase bits, built from the quarter-wave magnitudes.
  function automatic logic signed [7:0] phase_sine(input logic [25:0] ph);
    logic [7:0] k;
    int         mag;
    k = ph[25:18];
    if (k[6]) mag = QUARTER_SINE[64 - k[5:0]];
    else mag = QUARTER_SINE[k[5:0]];
    return k[7] ? 8'(-mag) : 8'(mag);
  endfunction

  // Advance the sequencer by one accepted transaction; ticks queue a result.
  function automatic void apply_item(input logic [1:0] mode, input logic [4:0] slot,
                                     input logic [25:0] load);
    iq_result_t  r;
    logic [3:0]  idx;
    logic [25:0] inc;
    int          s;
    int          g;
    int          delta;
    r = '{default: '0};
    case (mode_t'(mode))
      MODE_LOAD_DIGIT: begin
        if (slot < MESSAGE_SLOTS) digit_mem[slot] = load[7:0];
      end
      MODE_LOAD_TONE: begin
        if (slot < TONE_COUNT) tone_mem[slot[3:0]] = load;
      end
      MODE_START: begin
        dig_ptr    = '0;
        cur_digit  = '0;
        step_cnt   = spt_reg;
        lead_in    = 1'b1;
        seq_active = 1'b1;
      end
      default: begin
        if (seq_active) begin
          if (div_cnt >= TONE_DIVIDE - 1) begin
            div_cnt = '0;
            if (lead_in) begin
              if (step_cnt >= silence_reg) begin
                lead_in  = 1'b0;
                step_cnt = spt_reg;
              end else begin
                step_cnt++;
              end
            end else begin
              if (step_cnt >= spt_reg) begin
                cur_digit = digit_mem[dig_ptr];
                dig_ptr   = dig_ptr + 5'd1;
                if (cur_digit == END_DIGIT || dig_ptr >= MESSAGE_SLOTS) begin
                  seq_active = 1'b0;
                  r.finished = 1'b1;
                end else begin
                  r.digit_advanced = 1'b1;
                end
                step_cnt = '0;
              end else begin
                step_cnt++;
              end
              // the ending step leaves the tone phase where it was
              if (!r.finished) begin
                idx      = cur_digit[3:0];
                inc      = (idx < TONE_COUNT) ? tone_mem[idx] : '0;
                tone_acc = tone_acc + inc;
              end
            end
          end else begin
            div_cnt++;
          end
          if (seq_active && !lead_in) begin
            s           = phase_sine(tone_acc);
            g           = gain_reg;
            delta       = s * g;
            carrier_acc = carrier_acc + delta[25:0];
            r.i_sample  = phase_sine(carrier_acc + 26'h100_0000);
            r.q_sample  = phase_sine(carrier_acc);
          end
        end
        r.running     = seq_active;
        r.digits_done = dig_ptr;
        expected_samples.push_back(r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      spt_reg     = SPT_RESET;
      silence_reg = SILENCE_RESET;
      gain_reg    = GAIN_RESET;
      div_cnt     = '0;
      lead_in     = 1'b1;
      seq_active  = 1'b0;
      step_cnt    = '0;
      dig_ptr     = '0;
      cur_digit   = '0;
      tone_acc    = '0;
      carrier_acc = '0;
      expected_samples.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_TONE_STEPS:    spt_reg     = cfg_pwdata[15:0];
          REG_SILENCE_STEPS: silence_reg = cfg_pwdata[15:0];
          REG_FM_GAIN:       gain_reg    = cfg_pwdata[11:0];
          default: ;
        endcase
      end
      // check the outgoing transaction before queueing the incoming one
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected result i=%0d q=%0d done=%0d",
                                  out_i_sample, out_q_sample, out_digits_done));
        end else begin
          got_exp = expected_samples.pop_front();
          if (out_i_sample !== got_exp.i_sample)
            flag_mismatch($sformatf("i_sample %0d, want %0d", out_i_sample, got_exp.i_sample));
          if (out_q_sample !== got_exp.q_sample)
            flag_mismatch($sformatf("q_sample %0d, want %0d", out_q_sample, got_exp.q_sample));
          if (out_running !== got_exp.running)
            flag_mismatch($sformatf("running %b, want %b", out_running, got_exp.running));
          if (out_digit_advanced !== got_exp.digit_advanced)
            flag_mismatch($sformatf("digit_advanced %b, want %b",
                                    out_digit_advanced, got_exp.digit_advanced));
          if (out_digits_done !== got_exp.digits_done)
            flag_mismatch($sformatf("digits_done %0d, want %0d",
                                    out_digits_done, got_exp.digits_done));
          if (out_finished !== got_exp.finished)
            flag_mismatch($sformatf("finished %b, want %b", out_finished, got_exp.finished));
        end
      end
      if (in_valid && in_ready) apply_item(in_mode, in_slot, in_load_value);
    end
    pending_samples <= expected_samples.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the selcall FM modulator: clock, reset, stimulus, flow control, verdict.
`timescale 1ns / 1ps
module tb_top
  import scfm_pkg::*;
();

  localparam int MESSAGE_SLOTS = 21;
  localparam int TONE_DIVIDE   = 5;
  localparam int TONE_COUNT    = 16;
  // generous: every item waiting out both sides' longest gaps, plus hold-off and drains
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_mode;
  logic [4:0]        in_slot;
  logic [25:0]       in_load_value;
  logic              out_valid;
  logic              out_ready;
  logic signed [7:0] out_i_sample;
  logic signed [7:0] out_q_sample;
  logic              out_running;
  logic              out_digit_advanced;
  logic [4:0]        out_digits_done;
  logic              out_finished;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [3:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int                mismatch_count;
  int                pending_samples;
  int unsigned       cycle_count;

  // Flow-control knobs shared between the stimulus and the receiver.
  bit                sender_quiet;
  bit                receiver_quiet;
  bit                hold_request;

  selcall_tone_sequence_fm_modulator_unit #(
    .MESSAGE_SLOTS (MESSAGE_SLOTS),
    .TONE_DIVIDE   (TONE_DIVIDE),
    .TONE_COUNT    (TONE_COUNT)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_slot            (in_slot),
    .in_load_value      (in_load_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_i_sample       (out_i_sample),
    .out_q_sample       (out_q_sample),
    .out_running        (out_running),
    .out_digit_advanced (out_digit_advanced),
    .out_digits_done    (out_digits_done),
    .out_finished       (out_finished),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  scfm_checker #(
    .MESSAGE_SLOTS (MESSAGE_SLOTS),
    .TONE_DIVIDE   (TONE_DIVIDE),
    .TONE_COUNT    (TONE_COUNT)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_slot            (in_slot),
    .in_load_value      (in_load_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_i_sample       (out_i_sample),
    .out_q_sample       (out_q_sample),
    .out_running        (out_running),
    .out_digit_advanced (out_digit_advanced),
    .out_digits_done    (out_digits_done),
    .out_finished       (out_finished),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_pready         (cfg_pready),
    .mismatch_count     (mismatch_count),
    .pending_samples    (pending_samples)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("selcall_tone_sequence_fm_modulator_unit: mismatch");
      $finish;
    end
  end

  // Receiver: draw a stall per result; on request, hold off for a long stretch so the
  // block backs up and drops in_ready while the sender keeps offering.
  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = receiver_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one transaction after a random gap, and hold it until accepted.
  task automatic send_item(input mode_t mode, input logic [4:0] slot, input logic [25:0] load);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_slot       <= slot;
    in_load_value <= load;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, 5'($urandom()), 26'($urandom()));
  endtask

  // Drop valid and wait until every predicted result has come out, then let the
  // pipeline settle so a trailing load or start has landed before any register write.
  task automatic drain_samples();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup phase, then access phase; return to idle afterwards so back-to-back writes never
  // lower and raise psel in the same step.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] spt, input logic [15:0] silence,
                           input logic [11:0] gain);
    drain_samples();
    write_reg(REG_TONE_STEPS, 32'(spt));
    write_reg(REG_SILENCE_STEPS, 32'(silence));
    write_reg(REG_FM_GAIN, 32'(gain));
  endtask

  // Mostly ticks so sequences run deep; sprinkle digit and tone reloads (a few out of
  // range), end digits and restarts.
  task automatic random_traffic(input int n);
    int          pick;
    logic [4:0]  slot;
    logic [25:0] load;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      slot = 5'($urandom());
      load = 26'($urandom());
      if (pick < 83) begin
        send_item(MODE_TICK, slot, load);
      end else if (pick < 90) begin
        if ($urandom_range(0, 7) != 0) slot = 5'($urandom_range(0, MESSAGE_SLOTS - 1));
        case ($urandom_range(0, 3))
          0: load[7:0] = END_DIGIT;
          1: load[7:0] = 8'($urandom_range(0, 15));
          default: ;
        endcase
        send_item(MODE_LOAD_DIGIT, slot, load);
      end else if (pick < 96) begin
        if ($urandom_range(0, 7) != 0) slot = 5'($urandom_range(0, TONE_COUNT - 1));
        send_item(MODE_LOAD_TONE, slot, load);
      end else begin
        send_item(MODE_START, slot, load);
      end
    end
  endtask

  task automatic run_random_phase(input bit quiet, input bit long_hold);
    configure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
              12'($urandom_range(0, 4095)));
    sender_quiet   = quiet;
    receiver_quiet = quiet;
    if (long_hold) begin
      sender_quiet = 1'b1;
      hold_request = 1'b1;
    end
    send_item(MODE_START, 5'($urandom()), 26'($urandom()));
    random_traffic(25);
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin : stimulus
    int          s;
    logic [25:0] v;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_TICK;
    in_slot        <= '0;
    in_load_value  <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    hold_request   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every digit slot and tone entry first, so no sequence reads a stale entry.
    // Slots 0..3: lowest digit, a large digit folded to its low nibble, top digit, end.
    for (s = 0; s < MESSAGE_SLOTS; s++) begin
      v = 26'($urandom());
      case (s)
        0: v[7:0] = 8'h00;
        1: v[7:0] = 8'hA7;
        2: v[7:0] = 8'h0F;
        3: v[7:0] = END_DIGIT;
        default: v[7:0] = 8'($urandom_range(0, 15));
      endcase
      send_item(MODE_LOAD_DIGIT, 5'(s), v);
    end
    for (s = 0; s < TONE_COUNT; s++) begin
      case (s)
        0: v = '1;
        1: v = '0;
        default: v = 26'($urandom_range(1 << 14, 1 << 22));
      endcase
      send_item(MODE_LOAD_TONE, 5'(s), v);
    end

    // Directed: idle ticks with both field extremes, ignored out-of-range loads,
    // then a sequence at the reset configuration.
    send_item(MODE_TICK, '0, '0);
    send_item(MODE_TICK, '1, '1);
    send_item(MODE_LOAD_DIGIT, 5'(MESSAGE_SLOTS), 26'h0000_003);
    send_item(MODE_LOAD_DIGIT, '1, '1);
    send_item(MODE_LOAD_TONE, 5'(TONE_COUNT), 26'h0123456);
    send_item(MODE_LOAD_TONE, '1, '1);
    send_item(MODE_START, '0, '0);
    send_ticks(4);

    // Fastest tone steps and full deviation: restart mid-sequence, walk digits 0, 7 and 15,
    // and stop on the end digit.
    configure(16'd0, 16'd0, 12'hFFF);
    send_item(MODE_START, '1, '1);
    send_ticks(28);

    // No end digit in the store: run until the last slot is consumed.
    send_item(MODE_LOAD_DIGIT, 5'd3, 26'h0000_035);
    send_item(MODE_START, '0, '0);
    send_ticks(125);
    send_item(MODE_LOAD_DIGIT, 5'd3, 26'(END_DIGIT));

    // Largest step counts, zero gain: lead-in ends at once, carrier never moves.
    configure(16'hFFFF, 16'hFFFF, 12'd0);
    send_item(MODE_START, '0, '0);
    send_ticks(40);

    // Short tones behind the longest lead-in: outputs stay silent.
    configure(16'd3, 16'hFFFF, 12'd2048);
    send_item(MODE_START, '0, '0);
    send_ticks(30);

    // Random phases; two run without gaps, one under the long receiver hold-off.
    for (s = 0; s < 10; s++) run_random_phase(s == 1 || s == 6, s == 3);

    drain_samples();
    if (mismatch_count == 0) begin
      $display("selcall_tone_sequence_fm_modulator_unit: match");
    end else begin
      $display("selcall_tone_sequence_fm_modulator_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- selcall_tone_sequence_fm_modulator_unit.f -----
src/scfm_pkg.sv
src/scfm_seq.sv
src/selcall_tone_sequence_fm_modulator_unit.sv
src/scfm_chk.sv
bench/scfm_checker.sv
bench/tb_top.sv
